### rtl/core/s3f_pkg.sv
package s3f_pkg;

    // Field widths of the stream words
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int KEY_W    = 64;
    localparam int SIZE_W   = 32;
    localparam int WANT_W   = 40;
    localparam int FILES_W  = 7;
    localparam int TOTAL_W  = 38;
    localparam int SHARE_W  = 7;
    localparam int FREQ_W   = 2;
    localparam int META_W   = FREQ_W + 1;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 8;

    // Bit positions inside the input tdata
    localparam int SLOT_LSB = 0;
    localparam int KEY_LSB  = SLOT_LSB + SLOT_W;
    localparam int SIZE_LSB = KEY_LSB + KEY_W;
    localparam int WB_LSB   = SIZE_LSB + SIZE_W;
    localparam int WF_LSB   = WB_LSB + WANT_W;

    // Limits and reset values
    localparam logic [FILES_W-1:0] RESULT_CAP = 7'd64;
    localparam logic [SHARE_W-1:0] SHARE_RST  = 7'd10;
    localparam logic [FREQ_W-1:0]  FREQ_RST   = 2'd3;
    localparam logic [6:0]         PERCENT    = 7'd100;

    // Configuration register indexes
    localparam logic CFG_SHARE   = 1'b0;
    localparam logic CFG_MAXFREQ = 1'b1;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ACCESS = 2'd1,
        MODE_ERASE  = 2'd2,
        MODE_EVICT  = 2'd3
    } t_mode;

    // Frequency written with a queue push
    typedef enum logic [1:0] {
        PF_ZERO = 2'd0,
        PF_KEEP = 2'd1,
        PF_DEC  = 2'd2
    } t_pf;

    typedef struct packed {
        logic latch;
        logic ins_wr;
        logic acc_wr;
        logic unlink;
        logic sub_rd;
        logic clr_valid;
        logic main_sub;
        logic mult;
        logic sel_s;
        logic push;
        logic push_add;
        logic push2;
        t_pf  pf;
        logic q_main;
        logic g_clr;
        logic g_inc;
        logic g_rd1;
        logic g_copy;
        logic g_rm_fin;
        logic g_add;
        logic g_pop;
        logic victim;
        logic emit_fin;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  slot_ok;
        logic  vld;
        logic  rd_in_main;
        logic  g_end;
        logic  g_more;
        logic  g_hit;
        logic  g_over;
        logic  ev_go;
        logic  small_nz;
        logic  main_nz;
        logic  small_ge;
        logic  sf_nz;
        logic  pend;
        logic  out_free;
    } t_sts;

endpackage

### rtl/core/s3f_ctrl.sv
module s3f_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  s3f_pkg::t_sts i_sts,
    output s3f_pkg::t_cmd o_cmd
);
    import s3f_pkg::*;

    typedef enum logic [21:0] {
        ST_IDLE    = 22'h000001,
        ST_DEC     = 22'h000002,
        ST_INS_WR  = 22'h000004,
        ST_GF_RD   = 22'h000008,
        ST_GF_CK   = 22'h000010,
        ST_GR_RD   = 22'h000020,
        ST_GR_WR   = 22'h000040,
        ST_PUSH    = 22'h000080,
        ST_PUSH2   = 22'h000100,
        ST_ACC_RD  = 22'h000200,
        ST_ACC_WR  = 22'h000400,
        ST_ER_RD   = 22'h000800,
        ST_ER_UNL  = 22'h001000,
        ST_EV_CHK  = 22'h002000,
        ST_EV_SEL  = 22'h004000,
        ST_EV_RD   = 22'h008000,
        ST_EV_UNL  = 22'h010000,
        ST_EV_DEC  = 22'h020000,
        ST_EV_VIC  = 22'h040000,
        ST_GA_WR   = 22'h080000,
        ST_GA_TRIM = 22'h100000,
        ST_EV_FIN  = 22'h200000
    } t_state;

    t_state r_state, n_state;
    logic   r_small, n_small;
    logic   r_pmain, n_pmain;
    logic   ins;

    assign o_in_ready = (r_state == ST_IDLE);
    assign ins        = (i_sts.mode == MODE_INSERT);

    // Sequence one request through the datapath
    always_comb begin
        n_state = r_state;
        n_small = r_small;
        n_pmain = r_pmain;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DEC;
                end
            end
            ST_DEC: begin
                case (i_sts.mode)
                    MODE_INSERT: n_state = (i_sts.slot_ok && !i_sts.vld) ? ST_INS_WR : ST_IDLE;
                    MODE_ACCESS: n_state = (i_sts.slot_ok && i_sts.vld) ? ST_ACC_RD : ST_IDLE;
                    MODE_ERASE:  n_state = (i_sts.slot_ok && i_sts.vld) ? ST_ER_RD : ST_IDLE;
                    default:     n_state = ST_EV_CHK;
                endcase
            end
            ST_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                o_cmd.g_clr  = 1'b1;
                n_state      = ST_GF_RD;
            end
            ST_GF_RD: begin
                if (i_sts.g_end) begin
                    n_pmain = 1'b0;
                    n_state = ins ? ST_PUSH : ST_GA_WR;
                end else begin
                    n_state = ST_GF_CK;
                end
            end
            ST_GF_CK: begin
                if (i_sts.g_hit) begin
                    n_state = ins ? ST_GR_RD : ST_EV_CHK;
                end else begin
                    o_cmd.g_inc = 1'b1;
                    n_state     = ST_GF_RD;
                end
            end
            ST_GR_RD: begin
                o_cmd.g_rd1 = 1'b1;
                if (i_sts.g_more) begin
                    n_state = ST_GR_WR;
                end else begin
                    o_cmd.g_rm_fin = 1'b1;
                    n_pmain        = 1'b1;
                    n_state        = ST_PUSH;
                end
            end
            ST_GR_WR: begin
                o_cmd.g_copy = 1'b1;
                n_state      = ST_GR_RD;
            end
            ST_PUSH: begin
                o_cmd.push   = 1'b1;
                o_cmd.q_main = r_pmain;
                if (ins) begin
                    o_cmd.pf       = PF_ZERO;
                    o_cmd.push_add = 1'b1;
                end else begin
                    o_cmd.pf       = r_small ? PF_KEEP : PF_DEC;
                    o_cmd.push_add = r_small;
                end
                n_state = ST_PUSH2;
            end
            ST_PUSH2: begin
                o_cmd.push2 = 1'b1;
                n_state     = ins ? ST_IDLE : ST_EV_CHK;
            end
            ST_ACC_RD: n_state = ST_ACC_WR;
            ST_ACC_WR: begin
                o_cmd.acc_wr = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_ER_RD: n_state = ST_ER_UNL;
            ST_ER_UNL: begin
                o_cmd.unlink    = 1'b1;
                o_cmd.q_main    = i_sts.rd_in_main;
                o_cmd.sub_rd    = 1'b1;
                o_cmd.clr_valid = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_EV_CHK: begin
                if (i_sts.ev_go) begin
                    o_cmd.mult = 1'b1;
                    n_state    = ST_EV_SEL;
                end else begin
                    n_state = ST_EV_FIN;
                end
            end
            ST_EV_SEL: begin
                n_small = (i_sts.small_nz && i_sts.small_ge) || !i_sts.main_nz;
                o_cmd.sel_s  = 1'b1;
                o_cmd.q_main = !n_small;
                n_state      = ST_EV_RD;
            end
            ST_EV_RD: n_state = ST_EV_UNL;
            ST_EV_UNL: begin
                o_cmd.unlink = 1'b1;
                o_cmd.q_main = !r_small;
                o_cmd.sub_rd = r_small;
                n_state      = ST_EV_DEC;
            end
            ST_EV_DEC: begin
                if (i_sts.sf_nz) begin
                    n_pmain = 1'b1;
                    n_state = ST_PUSH;
                end else begin
                    o_cmd.clr_valid = 1'b1;
                    o_cmd.main_sub  = !r_small;
                    n_state         = ST_EV_VIC;
                end
            end
            ST_EV_VIC: begin
                // hold while the previous victim cannot leave
                if (!i_sts.pend || i_sts.out_free) begin
                    o_cmd.victim = 1'b1;
                    o_cmd.g_clr  = r_small;
                    n_state      = r_small ? ST_GF_RD : ST_EV_CHK;
                end
            end
            ST_GA_WR: begin
                o_cmd.g_add = 1'b1;
                n_state     = ST_GA_TRIM;
            end
            ST_GA_TRIM: begin
                if (i_sts.g_over) begin
                    o_cmd.g_pop = 1'b1;
                end else begin
                    n_state = ST_EV_CHK;
                end
            end
            ST_EV_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fin = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_small <= 1'b0;
            r_pmain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_small <= n_small;
            r_pmain <= n_pmain;
        end
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_fin || (o_cmd.victim && i_sts.pend)) |-> i_sts.out_free)
        else $error("result loaded while output busy");
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DEC))
        else $error("accepted word not decoded");
`endif

endmodule

### rtl/core/s3f_dpath.sv
module s3f_dpath #(
    parameter int ENTRIES     = 64,
    parameter int GHOST_DEPTH = 64,
    parameter int MIN_GHOST   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  s3f_pkg::t_cmd                     i_cmd,
    output s3f_pkg::t_sts                     o_sts,
    input  logic [s3f_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [s3f_pkg::MODE_W-1:0]        i_in_user,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [s3f_pkg::SHARE_W-1:0]       i_cfg_data,
    output logic [s3f_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic                              o_out_user,
    output logic                              o_out_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready
);
    import s3f_pkg::*;

    localparam int AW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int GW   = $clog2(GHOST_DEPTH);
    localparam int GCW  = $clog2(GHOST_DEPTH + 1);
    localparam int MGW  = $clog2(MIN_GHOST + 1);
    localparam int XW0  = (CW > GCW) ? CW : GCW;
    localparam int XW   = ((XW0 > MGW) ? XW0 : MGW) + 1;
    localparam int SLW  = (SLOT_W > CW) ? SLOT_W + 1 : CW + 1;
    localparam int PAW  = TOTAL_W + SHARE_W;
    localparam int PBW  = TOTAL_W + 1 + 7;

    // Slot tables
    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [SIZE_W-1:0] byte_mem [ENTRIES];
    logic [META_W-1:0] meta_mem [ENTRIES];
    logic [AW-1:0]     next_mem [ENTRIES];
    logic [AW-1:0]     prev_mem [ENTRIES];
    logic [KEY_W-1:0]  ghost_mem[GHOST_DEPTH];

    logic [ENTRIES-1:0] r_valid;

    logic [KEY_W-1:0]  rd_key;
    logic [SIZE_W-1:0] rd_bytes;
    logic [META_W-1:0] rd_meta;
    logic [AW-1:0]     rd_next;
    logic [AW-1:0]     rd_prev;
    logic [KEY_W-1:0]  g_rdata;

    // Latched request
    t_mode              r_mode;
    logic [SLOT_W-1:0]  r_in_slot;
    logic [SIZE_W-1:0]  r_size;
    logic [WANT_W-1:0]  r_want_bytes;
    logic [FILES_W-1:0] r_want_files;
    logic [AW-1:0]      r_s;
    logic [KEY_W-1:0]   r_k;
    logic [SIZE_W-1:0]  r_sb;
    logic [FREQ_W-1:0]  r_sf;

    // Queue state
    logic [AW-1:0]      r_small_head, r_small_tail, r_main_head, r_main_tail;
    logic [TOTAL_W-1:0] r_small_total, r_main_total;
    logic [CW-1:0]      r_small_entries, r_main_entries;
    logic [AW-1:0]      r_ot;
    logic               r_ne;

    // Ghost state
    logic [GW-1:0]      r_g_head, r_g_tail;
    logic [GCW-1:0]     r_g_entries;
    logic [GCW-1:0]     r_gi;

    // Evict bookkeeping
    logic [WANT_W-1:0]  r_freed;
    logic [FILES_W-1:0] r_n;
    logic               r_pend;
    logic [SLOT_W-1:0]  r_pend_slot;
    logic [PAW-1:0]     r_prod_a;
    logic [PBW-1:0]     r_prod_b;

    // Config and output
    logic [SHARE_W-1:0] r_share;
    logic [FREQ_W-1:0]  r_max_freq;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_found;
    logic               r_out_last;

    logic [AW-1:0]      q_head, q_tail;
    logic [CW-1:0]      q_cnt;
    logic [FREQ_W-1:0]  pf_val;
    logic               next_we, prev_we, meta_we;
    logic [AW-1:0]      next_wa, next_wd, prev_wa, prev_wd;
    logic [META_W-1:0]  meta_wd;
    logic [GW-1:0]      g_raddr, g_pos_i;
    logic [GCW-1:0]     gi_inc;
    logic [XW-1:0]      sum_e, cap;
    logic [TOTAL_W-1:0] total;
    logic               out_free;

    function automatic logic [GW-1:0] f_gpos(input logic [GW-1:0] head,
                                             input logic [GCW-1:0] i);
        logic [GCW:0] sum;
        sum = (GCW+1)'(head) + (GCW+1)'(i);
        if (sum >= (GCW+1)'(GHOST_DEPTH)) sum = sum - (GCW+1)'(GHOST_DEPTH);
        return sum[GW-1:0];
    endfunction

    function automatic logic [GW-1:0] f_ginc(input logic [GW-1:0] x);
        return (x == GW'(GHOST_DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    // Select the queue a command works on
    assign q_head = i_cmd.q_main ? r_main_head : r_small_head;
    assign q_tail = i_cmd.q_main ? r_main_tail : r_small_tail;
    assign q_cnt  = i_cmd.q_main ? r_main_entries : r_small_entries;

    always_comb begin
        case (i_cmd.pf)
            PF_KEEP: pf_val = r_sf;
            PF_DEC:  pf_val = r_sf - 1'b1;
            default: pf_val = '0;
        endcase
    end

    // Link table write ports
    always_comb begin
        next_we = 1'b0;
        next_wa = r_s;
        next_wd = r_s;
        prev_we = 1'b0;
        prev_wa = r_s;
        prev_wd = r_s;
        if (i_cmd.unlink) begin
            next_we = (r_s != q_head);
            next_wa = rd_prev;
            next_wd = rd_next;
            prev_we = (r_s != q_tail);
            prev_wa = rd_next;
            prev_wd = rd_prev;
        end else if (i_cmd.push) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            prev_wd = (q_cnt == '0) ? r_s : q_tail;
        end else if (i_cmd.push2) begin
            next_we = r_ne;
            next_wa = r_ot;
        end
    end

    // Frequency and queue tag write
    always_comb begin
        meta_we = 1'b0;
        meta_wd = {i_cmd.q_main, pf_val};
        if (i_cmd.push) begin
            meta_we = 1'b1;
        end else if (i_cmd.acc_wr && (rd_meta[FREQ_W-1:0] < r_max_freq)) begin
            meta_we = 1'b1;
            meta_wd = {rd_meta[FREQ_W], rd_meta[FREQ_W-1:0] + 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) key_mem[r_s] <= r_k;
        rd_key <= key_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) byte_mem[r_s] <= r_size;
        rd_bytes <= byte_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) meta_mem[r_s] <= meta_wd;
        rd_meta <= meta_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        rd_next <= next_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        rd_prev <= prev_mem[r_s];
    end

    // Ghost key store
    assign gi_inc  = r_gi + 1'b1;
    assign g_pos_i = f_gpos(r_g_head, r_gi);
    assign g_raddr = i_cmd.g_rd1 ? f_gpos(r_g_head, gi_inc) : g_pos_i;

    always_ff @(posedge i_clk) begin
        if (i_cmd.g_copy) ghost_mem[g_pos_i] <= g_rdata;
        else if (i_cmd.g_add) ghost_mem[r_g_tail] <= r_k;
        g_rdata <= ghost_mem[g_raddr];
    end

    // Ghost capacity follows the cached entry count, clamped to MIN_GHOST..GHOST_DEPTH
    assign sum_e = XW'(r_small_entries) + XW'(r_main_entries);
    always_comb begin
        cap = sum_e;
        if (cap < XW'(MIN_GHOST)) cap = XW'(MIN_GHOST);
        if (cap > XW'(GHOST_DEPTH)) cap = XW'(GHOST_DEPTH);
    end

    assign total    = r_small_total + r_main_total;
    assign out_free = !r_out_valid || i_out_ready;

    // Request, queue and ghost registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_small_head    <= '0;
            r_small_tail    <= '0;
            r_main_head     <= '0;
            r_main_tail     <= '0;
            r_small_total   <= '0;
            r_main_total    <= '0;
            r_small_entries <= '0;
            r_main_entries  <= '0;
            r_g_head        <= '0;
            r_g_tail        <= '0;
            r_g_entries     <= '0;
            r_gi            <= '0;
            r_n             <= '0;
            r_pend          <= 1'b0;
            r_share         <= SHARE_RST;
            r_max_freq      <= FREQ_RST;
            r_mode          <= MODE_INSERT;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SHARE) r_share <= i_cfg_data;
                else r_max_freq <= i_cfg_data[FREQ_W-1:0];
            end
            if (i_cmd.latch) begin
                r_mode <= t_mode'(i_in_user);
                r_n    <= '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.ins_wr) r_valid[r_s] <= 1'b1;
            if (i_cmd.clr_valid) r_valid[r_s] <= 1'b0;
            // unlink the slot from its queue
            if (i_cmd.unlink) begin
                if (i_cmd.q_main) begin
                    if (r_s == r_main_head) r_main_head <= rd_next;
                    if (r_s == r_main_tail) r_main_tail <= rd_prev;
                    if (r_main_entries != '0) r_main_entries <= r_main_entries - 1'b1;
                    if (i_cmd.sub_rd) r_main_total <= r_main_total - TOTAL_W'(rd_bytes);
                end else begin
                    if (r_s == r_small_head) r_small_head <= rd_next;
                    if (r_s == r_small_tail) r_small_tail <= rd_prev;
                    if (r_small_entries != '0) r_small_entries <= r_small_entries - 1'b1;
                    if (i_cmd.sub_rd) r_small_total <= r_small_total - TOTAL_W'(rd_bytes);
                end
            end
            // append the slot at a queue tail
            if (i_cmd.push) begin
                if (i_cmd.q_main) begin
                    if (r_main_entries == '0) r_main_head <= r_s;
                    r_main_tail    <= r_s;
                    r_main_entries <= r_main_entries + 1'b1;
                    if (i_cmd.push_add) r_main_total <= r_main_total + TOTAL_W'(r_sb);
                end else begin
                    if (r_small_entries == '0) r_small_head <= r_s;
                    r_small_tail    <= r_s;
                    r_small_entries <= r_small_entries + 1'b1;
                    if (i_cmd.push_add) r_small_total <= r_small_total + TOTAL_W'(r_sb);
                end
            end
            if (i_cmd.main_sub) r_main_total <= r_main_total - TOTAL_W'(r_sb);
            // ghost scan, removal, append and head trim
            if (i_cmd.g_clr) r_gi <= '0;
            if (i_cmd.g_inc || i_cmd.g_copy) r_gi <= gi_inc;
            if (i_cmd.g_rm_fin) begin
                r_g_entries <= r_g_entries - 1'b1;
                r_g_tail    <= f_gpos(r_g_head, r_g_entries - 1'b1);
            end
            if (i_cmd.g_add) begin
                r_g_tail <= f_ginc(r_g_tail);
                if (r_g_entries == GCW'(GHOST_DEPTH)) r_g_head <= f_ginc(r_g_head);
                else r_g_entries <= r_g_entries + 1'b1;
            end
            if (i_cmd.g_pop) begin
                r_g_head    <= f_ginc(r_g_head);
                r_g_entries <= r_g_entries - 1'b1;
            end
            if (i_cmd.victim) begin
                r_n    <= r_n + 1'b1;
                r_pend <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in_slot    <= i_in_data[SLOT_LSB +: SLOT_W];
            r_s          <= AW'(i_in_data[SLOT_LSB +: SLOT_W]);
            r_k          <= i_in_data[KEY_LSB +: KEY_W];
            r_size       <= i_in_data[SIZE_LSB +: SIZE_W];
            r_want_bytes <= i_in_data[WB_LSB +: WANT_W];
            r_want_files <= i_in_data[WF_LSB +: FILES_W];
            r_freed      <= '0;
        end
        if (i_cmd.ins_wr) r_sb <= r_size;
        if (i_cmd.unlink) begin
            r_sb <= rd_bytes;
            r_sf <= rd_meta[FREQ_W-1:0];
            if (r_mode == MODE_EVICT) r_k <= rd_key;
        end
        if (i_cmd.sel_s) r_s <= i_cmd.q_main ? r_main_head : r_small_head;
        if (i_cmd.push) begin
            r_ot <= q_tail;
            r_ne <= (q_cnt != '0);
        end
        if (i_cmd.mult) begin
            r_prod_a <= PAW'(total) * PAW'(r_share);
            r_prod_b <= PBW'({1'b0, r_small_total} + 1'b1) * PBW'(PERCENT);
        end
        if (i_cmd.victim) begin
            r_freed     <= r_freed + WANT_W'(r_sb);
            r_pend_slot <= SLOT_W'(r_s);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_fin || (i_cmd.victim && r_pend)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.victim && r_pend) begin
            r_out_slot  <= r_pend_slot;
            r_out_found <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (i_cmd.emit_fin) begin
            r_out_slot  <= r_pend ? r_pend_slot : '0;
            r_out_found <= r_pend;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_DATA_W'(r_out_slot);
    assign o_out_user  = r_out_found;
    assign o_out_last  = r_out_last;

    // Status to the controller
    assign o_sts.mode       = r_mode;
    assign o_sts.slot_ok    = SLW'(r_in_slot) < SLW'(ENTRIES);
    assign o_sts.vld        = r_valid[r_s];
    assign o_sts.rd_in_main = rd_meta[FREQ_W];
    assign o_sts.g_end      = (r_gi >= r_g_entries);
    assign o_sts.g_more     = ((GCW+1)'(r_gi) + 1'b1) < (GCW+1)'(r_g_entries);
    assign o_sts.g_hit      = (g_rdata == r_k);
    assign o_sts.g_over     = (XW'(r_g_entries) > cap);
    assign o_sts.ev_go      = ((r_freed < r_want_bytes) || (r_n < r_want_files)) &&
                              ((r_small_entries != '0) || (r_main_entries != '0)) &&
                              (r_n < RESULT_CAP);
    assign o_sts.small_nz   = (r_small_entries != '0);
    assign o_sts.main_nz    = (r_main_entries != '0);
    assign o_sts.small_ge   = (r_prod_b > PBW'(r_prod_a));
    assign o_sts.sf_nz      = (r_sf != '0);
    assign o_sts.pend       = r_pend;
    assign o_sts.out_free   = out_free;

`ifndef ASSERT_OFF
    a_ghost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_entries <= GCW'(GHOST_DEPTH))
        else $error("ghost count beyond depth");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CW+1)'(r_small_entries) + (CW+1)'(r_main_entries)) <= (CW+1)'(ENTRIES))
        else $error("queued entries beyond table size");
    a_victim_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.victim |=> (r_n <= RESULT_CAP) && r_pend)
        else $error("victim count beyond cap");
`endif

endmodule

### rtl/core/s3fifo_cache_replacement.sv
// S3-FIFO replacement engine over a table of ENTRIES slots. Each request word
// (tuser = mode) inserts, accesses, erases or evicts; only an evict returns
// words, one per freed slot with tlast on the final one, or a single word with
// tuser low when nothing was freed. Requests are handled one at a time by a
// controller stepping a datapath whose slot and ghost tables each have one
// read port. An insert scans the ghost keys and, on a ghost hit, shifts the
// keys behind the hit; an evict step that drops a small-queue entry also scans
// the ghost keys, and the ghost scan through its one read port bounds the
// rate. There is no clearing pass after reset; the result register lets the
// next request enter while the last result word waits.
module s3fifo_cache_replacement #(
    parameter int ENTRIES     = 64,
    parameter int GHOST_DEPTH = 64,
    parameter int MIN_GHOST   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] slot, [69:6] key, [101:70] size, [141:102] want_bytes,
    // [148:142] want_files
    input  logic [s3f_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] mode
    input  logic [s3f_pkg::MODE_W-1:0]        s_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [s3f_pkg::SHARE_W-1:0]       i_cfg_data,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] victim_slot
    output logic [s3f_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] victim_found
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import s3f_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    s3f_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    s3f_dpath #(
        .ENTRIES     (ENTRIES),
        .GHOST_DEPTH (GHOST_DEPTH),
        .MIN_GHOST   (MIN_GHOST)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule
